// ----- rtl/serial_loaded_bank_mapper_macros.svh -----
// ----------------------------------------------------------------------------
// serial_loaded_bank_mapper_macros
// Assertion helpers for the serial-loaded bank mapper.
// ----------------------------------------------------------------------------
`ifndef SERIAL_LOADED_BANK_MAPPER_MACROS_SVH
`define SERIAL_LOADED_BANK_MAPPER_MACROS_SVH

// Same-cycle implication, checked on every edge out of reset.
`define SBLM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sblm assertion failed");

// Next-cycle implication, checked on every edge out of reset.
`define SBLM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sblm assertion failed");

`endif

// ----- rtl/sblm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sblm_pkg
// Constants and codes shared by the serial-loaded bank mapper.
// ----------------------------------------------------------------------------
package sblm_pkg;

    // largest program ROM bank count honored
    localparam int PRG_BANK_LIMIT = 128;

    localparam logic [15:0] ADDR_ROM_BASE = 16'h8000;
    localparam logic [15:0] ADDR_RAM_LAST_IO = 16'h4017;

    localparam logic [4:0] CTRL_KEEP_MASK = 5'h13;  // 0xF3 within 5 bits
    localparam logic [4:0] CTRL_FORCE = 5'h0C;

    localparam int SHIFT_LOAD_POS = 4;

    // configuration register indexes
    localparam logic CFG_PRG_BANKS = 1'b0;
    localparam logic CFG_PRG_RAM_EN = 1'b1;

    // internal register select, from address bits 14:13
    localparam logic [1:0] REG_CTRL = 2'd0;
    localparam logic [1:0] REG_CHR0 = 2'd1;
    localparam logic [1:0] REG_CHR1 = 2'd2;
    localparam logic [1:0] REG_PRG = 2'd3;

endpackage

// ----- rtl/serial_loaded_bank_mapper.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_loaded_bank_mapper
// Serial-loaded bank mapper: CPU write decode, shift load and bank mapping.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one CPU write word:
//   i_cpu_address and i_write_data. Each accepted word yields exactly one
//   result word on the output channel (o_out_valid / i_out_ready): the
//   handled flag, a mapping_updated flag and the bank/mirroring fields
//   (zero unless mapping_updated is set).
//   The result is registered at the accepting edge.
//   Throughput is one word per cycle; the decode, shift and remap logic
//   sits between the input port and the result register in one pass.
//   A new word is taken while the held result is being taken in the same
//   cycle. If the receiver stalls, the result register holds and input
//   ready drops until it is taken.
//   Configuration (i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data) is
//   always ready; index 0 sets the 16 KB bank count, index 1 the PRG RAM
//   enable. Write it only while no word is in flight.
//   Reset (synchronous, active low) clears the shift state and the four
//   internal registers, sets the bank count to 16, RAM disabled, and
//   empties the result register.
// ----------------------------------------------------------------------------
`include "serial_loaded_bank_mapper_macros.svh"

module serial_loaded_bank_mapper (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // cpu write channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_cpu_address,
    input  logic [7:0]  i_write_data,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_handled,
    output logic        o_mapping_updated,
    output logic [1:0]  o_mirroring,
    output logic [6:0]  o_prg_bank_first,
    output logic [6:0]  o_prg_bank_second,
    output logic [4:0]  o_chr_bank_first,
    output logic [4:0]  o_chr_bank_second,
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    logic [7:0] r_prg_banks;
    logic       r_prg_ram_en;

    logic [4:0] r_shift_accum, n_shift_accum;
    logic [2:0] r_shift_count, n_shift_count;
    logic [4:0] r_ctrl, n_ctrl;
    logic [4:0] r_chr0, n_chr0;
    logic [4:0] r_chr1, n_chr1;
    logic [4:0] r_prg, n_prg;

    logic       r_out_valid;
    logic       r_handled, n_handled;
    logic       r_updated, n_updated;
    logic [1:0] r_mirroring, n_mirroring;
    logic [6:0] r_prg_first, n_prg_first;
    logic [6:0] r_prg_second, n_prg_second;
    logic [4:0] r_chr_first, n_chr_first;
    logic [4:0] r_chr_second, n_chr_second;

    logic       w_accept;
    logic [8:0] w_count;
    logic [6:0] w_last;
    logic [4:0] w_accum;
    logic [3:0] w_prg;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // clamp the bank count to 1..limit, last index masked to 7 bits
    always_comb begin
        if (r_prg_banks == 8'd0) begin
            w_count = 9'd1;
        end else if ({1'b0, r_prg_banks} > 9'(sblm_pkg::PRG_BANK_LIMIT)) begin
            w_count = 9'(sblm_pkg::PRG_BANK_LIMIT);
        end else begin
            w_count = {1'b0, r_prg_banks};
        end
        w_last = 7'(w_count - 9'd1);
    end

    always_comb begin
        n_shift_accum = r_shift_accum;
        n_shift_count = r_shift_count;
        n_ctrl        = r_ctrl;
        n_chr0        = r_chr0;
        n_chr1        = r_chr1;
        n_prg         = r_prg;
        n_handled     = 1'b0;
        n_updated     = 1'b0;
        n_mirroring   = 2'd0;
        n_prg_first   = 7'd0;
        n_prg_second  = 7'd0;
        n_chr_first   = 5'd0;
        n_chr_second  = 5'd0;
        // bits past the accumulator fall off the shift
        w_accum       = r_shift_accum | (5'(i_write_data[0]) << r_shift_count);
        w_prg         = n_prg[3:0];

        if (i_cpu_address < sblm_pkg::ADDR_ROM_BASE) begin
            // RAM window claimed only while the RAM is off
            n_handled = !r_prg_ram_en && (i_cpu_address > sblm_pkg::ADDR_RAM_LAST_IO);
        end else if (i_write_data[7]) begin
            n_ctrl        = (r_ctrl & sblm_pkg::CTRL_KEEP_MASK) | sblm_pkg::CTRL_FORCE;
            n_shift_accum = 5'd0;
            n_shift_count = 3'd0;
            n_handled     = 1'b1;
        end else if (r_shift_count >= 3'(sblm_pkg::SHIFT_LOAD_POS)) begin
            case (i_cpu_address[14:13])
                sblm_pkg::REG_CTRL: n_ctrl = w_accum;
                sblm_pkg::REG_CHR0: n_chr0 = w_accum;
                sblm_pkg::REG_CHR1: n_chr1 = w_accum;
                sblm_pkg::REG_PRG:  n_prg  = w_accum;
                default:            n_ctrl = w_accum;
            endcase
            n_shift_accum = 5'd0;
            n_shift_count = 3'd0;
            n_handled     = 1'b1;
            n_updated     = 1'b1;
            w_prg         = n_prg[3:0];

            n_mirroring = n_ctrl[1:0];
            if (n_ctrl[3]) begin
                if (n_ctrl[2]) begin
                    n_prg_first  = {3'd0, w_prg};
                    n_prg_second = w_last;
                end else begin
                    n_prg_first  = 7'd0;
                    n_prg_second = {3'd0, w_prg};
                end
            end else begin
                n_prg_first  = {3'd0, w_prg[3:1], 1'b0};
                n_prg_second = {3'd0, w_prg[3:1], 1'b1};
            end
            if (n_ctrl[4]) begin
                n_chr_first  = n_chr0;
                n_chr_second = n_chr1;
            end else begin
                n_chr_first  = {n_chr0[4:1], 1'b0};
                n_chr_second = {n_chr0[4:1], 1'b1};
            end
        end else begin
            n_shift_accum = w_accum;
            n_shift_count = r_shift_count + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_banks   <= 8'd16;
            r_prg_ram_en  <= 1'b0;
            r_shift_accum <= 5'd0;
            r_shift_count <= 3'd0;
            r_ctrl        <= 5'd0;
            r_chr0        <= 5'd0;
            r_chr1        <= 5'd0;
            r_prg         <= 5'd0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == sblm_pkg::CFG_PRG_BANKS) begin
                    r_prg_banks <= i_cfg_data;
                end else if (i_cfg_index == sblm_pkg::CFG_PRG_RAM_EN) begin
                    r_prg_ram_en <= i_cfg_data[0];
                end
            end
            if (w_accept) begin
                r_shift_accum <= n_shift_accum;
                r_shift_count <= n_shift_count;
                r_ctrl        <= n_ctrl;
                r_chr0        <= n_chr0;
                r_chr1        <= n_chr1;
                r_prg         <= n_prg;
                r_out_valid   <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_handled    <= n_handled;
            r_updated    <= n_updated;
            r_mirroring  <= n_mirroring;
            r_prg_first  <= n_prg_first;
            r_prg_second <= n_prg_second;
            r_chr_first  <= n_chr_first;
            r_chr_second <= n_chr_second;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_handled         = r_handled;
    assign o_mapping_updated = r_updated;
    assign o_mirroring       = r_mirroring;
    assign o_prg_bank_first  = r_prg_first;
    assign o_prg_bank_second = r_prg_second;
    assign o_chr_bank_first  = r_chr_first;
    assign o_chr_bank_second = r_chr_second;

    // shift position never passes the load slot
    `SBLM_ASSERT_NOW(a_shift_count_range, i_clk, i_rst_n, 1'b1,
        r_shift_count <= 3'(sblm_pkg::SHIFT_LOAD_POS))

    // a register load is always a claimed write
    `SBLM_ASSERT_NOW(a_update_claimed, i_clk, i_rst_n,
        o_out_valid && o_mapping_updated, o_handled)

    // mapping fields are blank on words without a load
    `SBLM_ASSERT_NOW(a_blank_fields, i_clk, i_rst_n,
        o_out_valid && !o_mapping_updated,
        o_mirroring == 2'd0 && o_prg_bank_first == 7'd0 && o_prg_bank_second == 7'd0 &&
        o_chr_bank_first == 5'd0 && o_chr_bank_second == 5'd0)

    // reset write clears the shift state
    `SBLM_ASSERT_NEXT(a_reset_write, i_clk, i_rst_n,
        w_accept && i_cpu_address[15] && i_write_data[7],
        r_shift_count == 3'd0 && r_shift_accum == 5'd0 && o_handled && r_ctrl[3:2] == 2'b11)

endmodule
